>>> rtl/core/fpa_pkg.sv
`timescale 1ns / 1ps

package fpa_pkg;

  typedef enum logic [3:0] {
    FN_ADD      = 4'd0,
    FN_SUB      = 4'd1,
    FN_MUL      = 4'd2,
    FN_DIV      = 4'd3,
    FN_MIN      = 4'd4,
    FN_MAX      = 4'd5,
    FN_INC      = 4'd6,
    FN_DEC      = 4'd7,
    FN_FROM_INT = 4'd8,
    FN_TO_INT   = 4'd9
  } func_t;

  typedef struct packed {
    func_t func;
    logic  neg;
    logic  less;
    logic  equal;
    logic  greater;
    logic  ovf;
    logic  dz;
  } flags_t;

  localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

endpackage

>>> rtl/core/fpa_front.sv
`timescale 1ns / 1ps

module fpa_front import fpa_pkg::*; #(
  parameter int FRACTION_BITS = 8,
  parameter int QW            = 40
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                vin,
  input  logic [3:0]          func,
  input  logic signed [31:0]  a,
  input  logic signed [31:0]  b,
  output logic                v_r,
  output flags_t              fl_r,
  output logic [31:0]         res_r,
  output logic signed [63:0]  prod_r,
  output logic [QW-1:0]       n_r,
  output logic [31:0]         d_r
);

  flags_t            fl_nxt;
  logic [31:0]       res_nxt;
  logic [32:0]       sum;
  logic [32:0]       dif;
  logic [31:0]       a_mag;
  logic [31:0]       b_mag;
  logic [FRACTION_BITS:0] top;
  logic              fit;

  always_comb begin
    sum   = {a[31], a} + {b[31], b};
    dif   = {a[31], a} - {b[31], b};
    a_mag = a[31] ? (32'd0 - a) : a;
    b_mag = b[31] ? (32'd0 - b) : b;
    top   = a[31:31-FRACTION_BITS];
    fit   = (&top) | ~(|top);

    fl_nxt         = '0;
    fl_nxt.func    = func_t'(func);
    fl_nxt.neg     = a[31] ^ b[31];
    fl_nxt.less    = a < b;
    fl_nxt.equal   = a == b;
    fl_nxt.greater = a > b;
    res_nxt        = '0;

    case (fl_nxt.func)
      FN_ADD: begin
        fl_nxt.ovf = sum[32] != sum[31];
        res_nxt    = fl_nxt.ovf ? (sum[32] ? Q_MIN : Q_MAX) : sum[31:0];
      end
      FN_SUB: begin
        fl_nxt.ovf = dif[32] != dif[31];
        res_nxt    = fl_nxt.ovf ? (dif[32] ? Q_MIN : Q_MAX) : dif[31:0];
      end
      FN_DIV: begin
        fl_nxt.dz = b == 32'sd0;
      end
      FN_MIN: res_nxt = fl_nxt.less ? a : b;
      FN_MAX: res_nxt = fl_nxt.greater ? a : b;
      FN_INC: begin
        fl_nxt.ovf = a == Q_MAX;
        res_nxt    = fl_nxt.ovf ? Q_MAX : a + 32'sd1;
      end
      FN_DEC: begin
        fl_nxt.ovf = a == Q_MIN;
        res_nxt    = fl_nxt.ovf ? Q_MIN : a - 32'sd1;
      end
      FN_FROM_INT: begin
        fl_nxt.ovf = !fit;
        res_nxt    = fit ? (a <<< FRACTION_BITS) : (a[31] ? Q_MIN : Q_MAX);
      end
      FN_TO_INT: res_nxt = a >>> FRACTION_BITS;
      default:   res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fl_r   <= fl_nxt;
      res_r  <= res_nxt;
      prod_r <= a * b;
      n_r    <= {a_mag, {FRACTION_BITS{1'b0}}};
      d_r    <= b_mag;
    end
  end

endmodule

>>> rtl/core/fpa_mul_rnd.sv
`timescale 1ns / 1ps

module fpa_mul_rnd import fpa_pkg::*; #(
  parameter int FRACTION_BITS = 8,
  parameter int QW            = 40
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                vin,
  input  flags_t              fl_in,
  input  logic [31:0]         res_in,
  input  logic signed [63:0]  prod,
  input  logic [QW-1:0]       n_in,
  input  logic [31:0]         d_in,
  output logic                v_r,
  output flags_t              fl_r,
  output logic [31:0]         res_r,
  output logic [QW-1:0]       n_r,
  output logic [31:0]         d_r
);

  localparam logic [63:0] HALF  = 64'd1 << (FRACTION_BITS - 1);
  localparam logic [63:0] POS_L = 64'h0000_0000_7fff_ffff;
  localparam logic [63:0] NEG_L = 64'h0000_0000_8000_0000;

  flags_t      fl_nxt;
  logic [31:0] res_nxt;
  logic [63:0] mag;
  logic [63:0] m;

  always_comb begin
    mag     = prod[63] ? (64'd0 - prod) : prod;
    m       = (mag + HALF) >> FRACTION_BITS;
    fl_nxt  = fl_in;
    res_nxt = res_in;
    if (fl_in.func == FN_MUL) begin
      if (!prod[63]) begin
        fl_nxt.ovf = m > POS_L;
        res_nxt    = fl_nxt.ovf ? Q_MAX : m[31:0];
      end else begin
        fl_nxt.ovf = m > NEG_L;
        res_nxt    = fl_nxt.ovf ? Q_MIN : (32'd0 - m[31:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fl_r  <= fl_nxt;
      res_r <= res_nxt;
      n_r   <= n_in;
      d_r   <= d_in;
    end
  end

endmodule

>>> rtl/core/fpa_div_step.sv
`timescale 1ns / 1ps

module fpa_div_step import fpa_pkg::*; #(
  parameter int QW = 40
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vin,
  input  flags_t        fl_in,
  input  logic [31:0]   res_in,
  input  logic [QW-1:0] nq_in,
  input  logic [31:0]   rem_in,
  input  logic [31:0]   d_in,
  output logic          v_r,
  output flags_t        fl_r,
  output logic [31:0]   res_r,
  output logic [QW-1:0] nq_r,
  output logic [31:0]   rem_r,
  output logic [31:0]   d_r
);

  logic [32:0] t;
  logic [32:0] td;
  logic        ge;

  always_comb begin
    t  = {rem_in, nq_in[QW-1]};
    ge = t >= {1'b0, d_in};
    td = t - {1'b0, d_in};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fl_r  <= fl_in;
      res_r <= res_in;
      nq_r  <= {nq_in[QW-2:0], ge};
      rem_r <= ge ? td[31:0] : t[31:0];
      d_r   <= d_in;
    end
  end

endmodule

>>> rtl/core/fpa_back.sv
`timescale 1ns / 1ps

module fpa_back import fpa_pkg::*; #(
  parameter int QW = 40
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vin,
  input  flags_t        fl_in,
  input  logic [31:0]   res_in,
  input  logic [QW-1:0] q_in,
  input  logic [31:0]   rem_in,
  input  logic [31:0]   d_in,
  output logic          v_r,
  output logic [31:0]   res_r,
  output logic [4:0]    flg_r
);

  localparam logic [QW:0] POS_L = (QW+1)'(64'h0000_0000_7fff_ffff);
  localparam logic [QW:0] NEG_L = (QW+1)'(64'h0000_0000_8000_0000);

  logic [QW:0] q;
  logic        up;
  logic        ovf;
  logic [31:0] res_nxt;

  always_comb begin
    up      = {rem_in, 1'b0} >= {1'b0, d_in};
    q       = {1'b0, q_in} + {{QW{1'b0}}, up};
    ovf     = fl_in.ovf;
    res_nxt = res_in;
    if (fl_in.func == FN_DIV) begin
      if (fl_in.dz) begin
        ovf     = 1'b0;
        res_nxt = '0;
      end else if (!fl_in.neg) begin
        ovf     = q > POS_L;
        res_nxt = ovf ? Q_MAX : q[31:0];
      end else begin
        ovf     = q > NEG_L;
        res_nxt = ovf ? Q_MIN : (32'd0 - q[31:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
      flg_r <= {fl_in.dz, ovf, fl_in.greater, fl_in.equal, fl_in.less};
    end
  end

endmodule

>>> rtl/core/fixed_point_alu.sv
`timescale 1ns / 1ps
// Signed fixed-point ALU, raw 32-bit operands with FRACTION_BITS fraction bits.
// Input stream: in_tuser carries the operation code, in_tdata the two operands.
// Result stream: out_tdata carries the result, out_tuser the compare and
// status flags (less, equal, greater, overflow, divide by zero).
// Every operation runs through the same pipeline: one front stage (simple ops,
// 32x32 multiply), one multiply rounding stage, 32+FRACTION_BITS restoring
// divide stages of one quotient bit each, and the output register.
// Throughput is one item per cycle unless the receiver stalls; the divide pipeline sets the depth.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_tready drops; nothing is lost or repeated.
// Reset clears all valid bits; the block takes items the cycle after reset.
// Divide by zero gives 0 with the flag set; out-of-range results saturate.
module fixed_point_alu import fpa_pkg::*; #(
  parameter int FRACTION_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // operand_a[31:0], operand_b[63:32]
  input  logic [3:0]  in_tuser,   // func[3:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // result[31:0]
  output logic [4:0]  out_tuser   // less, equal, greater, overflow, div_by_zero
);

  localparam int QW = 32 + FRACTION_BITS;

  logic               adv;
  logic               v_f;
  flags_t             fl_f;
  logic [31:0]        res_f;
  logic signed [63:0] prod_f;
  logic [QW-1:0]      n_f;
  logic [31:0]        d_f;

  logic               v_s   [0:QW];
  flags_t             fl_s  [0:QW];
  logic [31:0]        res_s [0:QW];
  logic [QW-1:0]      nq_s  [0:QW];
  logic [31:0]        rem_s [0:QW];
  logic [31:0]        d_s   [0:QW];

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  fpa_front #(.FRACTION_BITS(FRACTION_BITS), .QW(QW)) u_front (
    .clk(clk), .rst_n(rst_n), .en(adv), .vin(in_tvalid),
    .func(in_tuser), .a(in_tdata[31:0]), .b(in_tdata[63:32]),
    .v_r(v_f), .fl_r(fl_f), .res_r(res_f), .prod_r(prod_f), .n_r(n_f), .d_r(d_f)
  );

  fpa_mul_rnd #(.FRACTION_BITS(FRACTION_BITS), .QW(QW)) u_mul (
    .clk(clk), .rst_n(rst_n), .en(adv), .vin(v_f),
    .fl_in(fl_f), .res_in(res_f), .prod(prod_f), .n_in(n_f), .d_in(d_f),
    .v_r(v_s[0]), .fl_r(fl_s[0]), .res_r(res_s[0]), .n_r(nq_s[0]), .d_r(d_s[0])
  );

  assign rem_s[0] = '0;

  for (genvar i = 0; i < QW; i++) begin : g_div
    fpa_div_step #(.QW(QW)) u_step (
      .clk(clk), .rst_n(rst_n), .en(adv), .vin(v_s[i]),
      .fl_in(fl_s[i]), .res_in(res_s[i]), .nq_in(nq_s[i]), .rem_in(rem_s[i]),
      .d_in(d_s[i]),
      .v_r(v_s[i+1]), .fl_r(fl_s[i+1]), .res_r(res_s[i+1]), .nq_r(nq_s[i+1]),
      .rem_r(rem_s[i+1]), .d_r(d_s[i+1])
    );
  end

  fpa_back #(.QW(QW)) u_back (
    .clk(clk), .rst_n(rst_n), .en(adv), .vin(v_s[QW]),
    .fl_in(fl_s[QW]), .res_in(res_s[QW]), .q_in(nq_s[QW]), .rem_in(rem_s[QW]),
    .d_in(d_s[QW]),
    .v_r(out_tvalid), .res_r(out_tdata), .flg_r(out_tuser)
  );

`ifndef SYNTHESIS
  a_cmp_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot(out_tuser[2:0]))
    else $error("compare flags not exclusive");

  a_dz_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[4] |-> out_tdata == 32'd0 && !out_tuser[3] && out_tuser[1] == 1'b0
      || out_tvalid && out_tuser[4] && out_tdata == 32'd0 && !out_tuser[3]
         && out_tuser[1] == 1'b1 && out_tuser[0] == 1'b0)
    else $error("divide by zero result not clean");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    v_s[QW] && out_tvalid && !out_tready |=> v_s[QW])
    else $error("pipeline item dropped during stall");
`endif

endmodule
